/* hdl/cb32_pkg.sv */
package cb32_pkg;

  // Group geometry
  localparam int unsigned GroupW   = 48;
  localparam int unsigned DataW    = 40;
  localparam int unsigned FillW    = 4;
  localparam int unsigned CountW   = 3;
  localparam int unsigned IdxW     = 3;

  // Job queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Register map: index taken from paddr bit 2
  localparam logic RegDirection = 1'b0;

  // Direction codes
  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  localparam logic [7:0] PadChar = 8'h3D;
  localparam logic [5:0] PadCode = 6'd32;

  localparam logic [255:0] Alphabet = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

  // One queued group: encode keeps the 40 aligned bits, decode the five bytes
  typedef struct packed {
    logic               dec;
    logic [CountW-1:0]  n;
    logic [DataW-1:0]   data;
  } job_t;

  typedef struct packed {
    logic ok;
    logic [5:0] code;
  } code_t;

  typedef struct packed {
    logic we;
    logic dir;
  } cfg_wr_t;

  // Character for a 5-bit index
  function automatic logic [7:0] alpha_char(input logic [4:0] idx);
    logic [7:0] ch;
    ch = Alphabet[8 * (31 - int'(idx)) +: 8];
    return ch;
  endfunction

  // Map an ASCII character to its code; ok low means dropped
  function automatic code_t char_code(input logic [7:0] c);
    code_t      r;
    logic [7:0] u;
    r.ok   = 1'b1;
    r.code = '0;
    u      = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.code = 6'(c - 8'h30);
    end else if (c == PadChar) begin
      r.code = PadCode;
    end else if (u >= 8'h41 && u <= 8'h48) begin
      r.code = 6'(u - 8'h41 + 8'd10);
    end else if (u >= 8'h4A && u <= 8'h4B) begin
      r.code = 6'(u - 8'h41 + 8'd9);
    end else if (u >= 8'h4D && u <= 8'h4E) begin
      r.code = 6'(u - 8'h41 + 8'd8);
    end else if (u >= 8'h50 && u <= 8'h54) begin
      r.code = 6'(u - 8'h41 + 8'd7);
    end else if (u >= 8'h56 && u <= 8'h5A) begin
      r.code = 6'(u - 8'h41 + 8'd6);
    end else if (u == 8'h49 || u == 8'h4C) begin
      r.code = 6'd1;
    end else if (u == 8'h4F) begin
      r.code = 6'd0;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Align n pending bytes (1..5) to the top of 40 bits
  function automatic job_t enc_job(input logic [DataW-1:0] g, input logic [CountW-1:0] n);
    job_t j;
    j.dec = 1'b0;
    j.n   = n;
    case (n)
      3'd1:    j.data = {g[7:0], 32'd0};
      3'd2:    j.data = {g[15:0], 24'd0};
      3'd3:    j.data = {g[23:0], 16'd0};
      3'd4:    j.data = {g[31:0], 8'd0};
      default: j.data = g;
    endcase
    return j;
  endfunction

  // Turn eight codes into up to five bytes, padding trims the count
  function automatic job_t dec_job(input logic [GroupW-1:0] g);
    job_t       j;
    logic [5:0] a [8];
    logic [2:0] skip;
    logic [7:0] b0, b1, b2, b3, b4;
    for (int k = 0; k < 8; k++) begin
      a[k] = g[GroupW - 1 - 6 * k -: 6];
    end
    skip = 3'd0;
    if (a[7] == PadCode) begin
      a[7] = '0;
      skip = 3'd1;
    end
    if (a[5] == PadCode) begin
      a[5] = '0;
      a[6] = '0;
      skip = 3'd2;
    end
    if (a[4] == PadCode) begin
      a[4] = '0;
      skip = 3'd3;
    end
    if (a[2] == PadCode) begin
      a[2] = '0;
      a[3] = '0;
      skip = 3'd4;
    end
    b0 = {a[0][4:0], 3'd0} | {4'd0, a[1][5:2]};
    b1 = {a[1][1:0], 6'd0} | {1'b0, a[2], 1'b0} | {6'd0, a[3][5:4]};
    b2 = {a[3][3:0], 4'd0} | {3'd0, a[4][5:1]};
    b3 = {a[4][0], 7'd0} | {a[5], 2'd0} | {5'd0, a[6][5:3]};
    b4 = {a[6][2:0], 5'd0} | {2'd0, a[7]};
    j.dec  = 1'b1;
    j.n    = 3'd5 - skip;
    j.data = {b0, b1, b2, b3, b4};
    return j;
  endfunction

  // Fewest pending bytes for which encode character k is real data
  function automatic logic [CountW-1:0] min_bytes(input logic [IdxW-1:0] k);
    logic [CountW-1:0] m;
    case (k)
      3'd0, 3'd1: m = 3'd1;
      3'd2, 3'd3: m = 3'd2;
      3'd4:       m = 3'd3;
      3'd5, 3'd6: m = 3'd4;
      default:    m = 3'd5;
    endcase
    return m;
  endfunction

endpackage

/* hdl/cb32_front.sv */
module cb32_front
  import cb32_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_wr_t    cfg_i,
  output logic       dir_o,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_eod_i,
  output logic       push_o,
  output job_t       push_job_o,
  input  logic       full_i
);

  logic              dir_q;
  logic [GroupW-1:0] grp_q, grp_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic              take;
  logic [FillW-1:0]  fill_inc;
  logic [GroupW-1:0] enc_grp, dec_grp;
  code_t             cc;

  assign in_ready_o = ~full_i;
  assign take       = in_valid_i & ~full_i;
  assign dir_o      = dir_q;
  assign fill_inc   = fill_q + FillW'(1);
  assign cc         = char_code(in_byte_i);
  assign enc_grp    = {grp_q[GroupW-9:0], in_byte_i};
  assign dec_grp    = {grp_q[GroupW-7:0], cc.code};

  // Gather one group and hand it to the queue when complete, or at end of data when encoding
  always_comb begin
    grp_d      = grp_q;
    fill_d     = fill_q;
    push_o     = 1'b0;
    push_job_o = enc_job(enc_grp[DataW-1:0], fill_inc[CountW-1:0]);
    if (take) begin
      if (dir_q == DirEncode) begin
        grp_d  = enc_grp;
        fill_d = fill_inc;
        if (fill_inc >= FillW'(5) || in_eod_i) begin
          push_o = 1'b1;
          grp_d  = '0;
          fill_d = '0;
        end
      end else begin
        push_job_o = dec_job(dec_grp);
        if (cc.ok) begin
          grp_d  = dec_grp;
          fill_d = fill_inc;
          if (fill_inc >= FillW'(8)) begin
            push_o = 1'b1;
            grp_d  = '0;
            fill_d = '0;
          end
        end
        if (in_eod_i) begin
          grp_d  = '0;
          fill_d = '0;
        end
      end
    end
    if (cfg_i.we) begin
      grp_d  = '0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= DirEncode;
      grp_q  <= '0;
      fill_q <= '0;
    end else begin
      if (cfg_i.we) begin
        dir_q <= cfg_i.dir;
      end
      grp_q  <= grp_d;
      fill_q <= fill_d;
    end
  end

endmodule

/* hdl/cb32_queue.sv */
module cb32_queue
  import cb32_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  job_t             mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  // Store the request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

/* hdl/cb32_back.sv */
module cb32_back
  import cb32_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic [IdxW-1:0] k_q;
  logic            ov_q;
  logic [7:0]      ob_q;
  logic            ol_q;
  logic            load;
  logic [7:0]      res_byte;
  logic            res_last;
  logic [4:0]      idx;

  assign load  = job_valid_i & (~ov_q | out_ready_i);
  assign pop_o = load & res_last;
  assign idx   = job_i.data[DataW - 1 - 5 * int'(k_q) -: 5];

  // Pick the result for step k of the head job
  always_comb begin
    if (job_i.dec) begin
      res_byte = job_i.data[DataW - 1 - 8 * int'(k_q) -: 8];
      res_last = (CountW'(k_q) + CountW'(1)) == job_i.n;
    end else begin
      res_byte = (job_i.n >= min_bytes(k_q)) ? alpha_char(idx) : PadChar;
      res_last = k_q == IdxW'(7);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ob_q <= res_byte;
      ol_q <= res_last;
    end
  end

  // Hold the output until taken, step through the job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      if (load) begin
        ov_q <= 1'b1;
        k_q  <= res_last ? '0 : k_q + IdxW'(1);
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_last_o  = ol_q;

endmodule

/* hdl/crockford_base32_codec.sv */
// Channel   Dir  Handshake                     Contents
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: in_byte, tlast: end_of_data
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: out_byte, tlast: out_last
// apb       in   psel/penable/pready           reg 0 at 0x0: direction (bit 0)
//
// Input takes one item per cycle while the two-entry group queue has room.
// Output gives one result per cycle from the back end while m_axis_tready is
// high and a job is queued: eight characters per encoded group, one to five
// bytes per decoded group. The first result passes through the queue and then
// the output register after its group completes. Reset clears direction
// (encode) and the pending group; either side may stall without losing results.
module crockford_base32_codec
  import cb32_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_wr_t cfg;
  logic    dir;
  logic    push, full, pop, job_valid;
  job_t    push_job, head_job;

  // Decode the register write
  assign pready  = 1'b1;
  assign cfg.we  = psel & penable & pwrite & (paddr[2] == RegDirection);
  assign cfg.dir = pwdata[0];
  assign prdata  = (paddr[2] == RegDirection) ? {31'd0, dir} : 32'd0;

  cb32_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .dir_o      (dir),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_eod_i   (s_axis_tlast),
    .push_o     (push),
    .push_job_o (push_job),
    .full_i     (full)
  );

  cb32_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (job_valid),
    .head_o     (head_job)
  );

  cb32_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

/* hdl/cb32_checker.sv */
module cb32_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  logic dir_q;

  // Track the direction register from the bus
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      dir_q <= pwdata[0];
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_enc_charset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !dir_q |->
      (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) ||
      (m_axis_tdata >= 8'h41 && m_axis_tdata <= 8'h5A) ||
      (m_axis_tdata == 8'h3D))
    else $error("encoded character outside alphabet");

  a_dir_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && !paddr[2] |-> prdata[0] == dir_q)
    else $error("direction readback mismatch");

endmodule

bind crockford_base32_codec cb32_checker u_cb32_checker (.*);
